// File: sv/e2e_pkg.sv
// Shared types, constants and helper functions for the end-to-end message checker.
// Depends on nothing; every other file of the checker imports it.
package e2e_pkg;

	// Header and payload field layout, in byte positions from the start of the message.
	localparam int HDR_BYTES     = 12;
	localparam int POS_ID_END    = 4;
	localparam int POS_SEQ_LO    = 6;
	localparam int POS_SEQ_HI    = 7;
	localparam int POS_CRC_BEGIN = 8;
	localparam int POS_CRC_END   = 12;
	localparam int POS_SPD_END   = 16;
	localparam int POS_ACC_END   = 20;
	localparam int POS_QUALITY   = 20;

	// CRC-32, reflected form.
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

	// Range bounds as IEEE-754 single magnitudes.
	localparam logic [30:0] SPEED_NEG_MAG = 31'h40A0_0000;  // 5.0
	localparam logic [30:0] SPEED_HI      = 31'h42B4_0000;  // 90.0
	localparam logic [30:0] ACCEL_NEG_MAG = 31'h4170_0000;  // 15.0
	localparam logic [30:0] ACCEL_HI      = 31'h4170_0000;  // 15.0
	localparam logic [7:0]  QUALITY_MAX   = 8'd2;

	// Status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_WRONG_CRC = 3'd1;
	localparam logic [2:0] ST_LOST     = 3'd2;
	localparam logic [2:0] ST_REPEATED = 3'd3;
	localparam logic [2:0] ST_RANGE    = 3'd4;
	localparam logic [2:0] ST_WRONG_ID = 3'd5;
	localparam logic [2:0] ST_SIZE     = 3'd6;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PLAUS_EN    = 1'd1;

	// One received message as classified by the front end.
	typedef struct packed {
		logic        size_ok;
		logic        crc_ok;
		logic [31:0] id;
		logic [15:0] seq;
		logic [31:0] speed;
		logic [31:0] accel;
		logic [7:0]  quality;
	} msg_rec_t;

	// One byte step of the reflected CRC-32.
	function automatic logic [31:0] crc32_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

	// True when a float bit pattern lies in [-neg_mag, hi]; NaN is above every bound.
	function automatic logic float_in(input logic [31:0] bits, input logic [30:0] neg_mag,
			input logic [30:0] hi);
		logic ok;
		if (bits[31]) begin
			ok = (bits[30:0] <= neg_mag);
		end else begin
			ok = (bits[30:0] <= hi);
		end
		return ok;
	endfunction

endpackage

// File: sv/e2e_ingest.sv
// Front end: takes message bytes, runs the CRC, captures header and payload fields.
// Pushes one classified message record per last byte. Depends on e2e_pkg.
module e2e_ingest #(
	parameter int PAYLOAD_BYTES = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        msg_byte,
	input  logic              is_last,
	output logic              q_push,
	output e2e_pkg::msg_rec_t q_rec,
	input  logic              q_full
);
	import e2e_pkg::*;

	localparam int MSG_BYTES = HDR_BYTES + PAYLOAD_BYTES;
	localparam int POS_W     = $clog2(MSG_BYTES + 1);

	logic [POS_W-1:0] pos_q, pos_n;
	logic [31:0]      crc_q, crc_n;
	logic [31:0]      id_q, id_n;
	logic [15:0]      seq_q, seq_n;
	logic [31:0]      fcrc_q, fcrc_n;
	logic [31:0]      speed_q, speed_n;
	logic [31:0]      accel_q, accel_n;
	logic [7:0]       quality_q, quality_n;
	logic [1:0]       lane;
	logic             accept;

	// A byte waits only while the queue has no room.
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign lane     = pos_q[1:0];

	// Field capture and CRC update for the current byte.
	always_comb begin
		id_n      = id_q;
		seq_n     = seq_q;
		fcrc_n    = fcrc_q;
		speed_n   = speed_q;
		accel_n   = accel_q;
		quality_n = quality_q;
		if (pos_q < POS_W'(POS_ID_END)) begin
			id_n[8*lane +: 8] = msg_byte;
		end
		if (pos_q == POS_W'(POS_SEQ_LO)) begin
			seq_n[7:0] = msg_byte;
		end
		if (pos_q == POS_W'(POS_SEQ_HI)) begin
			seq_n[15:8] = msg_byte;
		end
		if (pos_q >= POS_W'(POS_CRC_BEGIN) && pos_q < POS_W'(POS_CRC_END)) begin
			fcrc_n[8*lane +: 8] = msg_byte;
		end
		if (pos_q >= POS_W'(POS_CRC_END) && pos_q < POS_W'(POS_SPD_END)) begin
			speed_n[8*lane +: 8] = msg_byte;
		end
		if (pos_q >= POS_W'(POS_SPD_END) && pos_q < POS_W'(POS_ACC_END)) begin
			accel_n[8*lane +: 8] = msg_byte;
		end
		if (pos_q == POS_W'(POS_QUALITY)) begin
			quality_n = msg_byte;
		end
		// The CRC field itself is skipped.
		if (pos_q < POS_W'(POS_CRC_BEGIN) || pos_q >= POS_W'(POS_CRC_END)) begin
			crc_n = crc32_byte(crc_q, msg_byte);
		end else begin
			crc_n = crc_q;
		end
		// The position saturates at the full message size.
		if (pos_q < POS_W'(MSG_BYTES)) begin
			pos_n = pos_q + POS_W'(1);
		end else begin
			pos_n = pos_q;
		end
	end

	// Record handed to the back end on the last byte.
	always_comb begin
		q_rec.size_ok = (pos_n == POS_W'(MSG_BYTES));
		q_rec.crc_ok  = ((crc_n ^ CRC_ONES) == fcrc_n);
		q_rec.id      = id_n;
		q_rec.seq     = seq_n;
		q_rec.speed   = speed_n;
		q_rec.accel   = accel_n;
		q_rec.quality = quality_n;
	end
	assign q_push = accept && is_last;

	// Per-message state; it returns to reset after every last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_q     <= CRC_ONES;
			id_q      <= '0;
			seq_q     <= '0;
			fcrc_q    <= '0;
			speed_q   <= '0;
			accel_q   <= '0;
			quality_q <= '0;
		end else if (accept) begin
			if (is_last) begin
				pos_q     <= '0;
				crc_q     <= CRC_ONES;
				id_q      <= '0;
				seq_q     <= '0;
				fcrc_q    <= '0;
				speed_q   <= '0;
				accel_q   <= '0;
				quality_q <= '0;
			end else begin
				pos_q     <= pos_n;
				crc_q     <= crc_n;
				id_q      <= id_n;
				seq_q     <= seq_n;
				fcrc_q    <= fcrc_n;
				speed_q   <= speed_n;
				accel_q   <= accel_n;
				quality_q <= quality_n;
			end
		end
	end

endmodule

// File: sv/e2e_queue.sv
// Two-entry queue of message records between the front end and the back end.
// Depends on e2e_pkg for the record type.
module e2e_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  e2e_pkg::msg_rec_t rec_in,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output e2e_pkg::msg_rec_t rec_out
);
	import e2e_pkg::*;

	msg_rec_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (count_q == 2'd2);
	assign valid   = (count_q != 2'd0);
	assign rec_out = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	// Storage is written at the write pointer.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= rec_in;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// File: sv/e2e_verdict.sv
// Back end: holds configuration and sequence state, decides the status of each
// message record and keeps the result in an output register. Depends on e2e_pkg.
module e2e_verdict (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [e2e_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           q_valid,
	input  e2e_pkg::msg_rec_t              q_rec,
	output logic                           q_pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     status,
	output logic [31:0]                    speed_bits,
	output logic [31:0]                    accel_bits,
	output logic [7:0]                     quality_code,
	output logic [15:0]                    seq_number
);
	import e2e_pkg::*;

	logic [31:0] expected_id_q;
	logic        plaus_en_q;
	logic [15:0] next_expected_q;
	logic        awaiting_first_q;
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [31:0] speed_q;
	logic [31:0] accel_q;
	logic [7:0]  quality_q;
	logic [15:0] seq_q;

	logic [2:0]  status_n;
	logic        keep_payload;
	logic        plaus_ok;
	logic        seq_update;
	logic [15:0] seq_diff;
	logic [15:0] seq_plus1;

	// A record moves on when the output register is empty or being taken.
	assign q_pop = q_valid && (!out_valid_q || !out_stall);

	assign plaus_ok = float_in(q_rec.speed, SPEED_NEG_MAG, SPEED_HI) &&
		float_in(q_rec.accel, ACCEL_NEG_MAG, ACCEL_HI) && (q_rec.quality <= QUALITY_MAX);
	assign seq_diff  = q_rec.seq - next_expected_q;
	assign seq_plus1 = q_rec.seq + 16'd1;

	// Status by precedence: size, id, CRC, range, then the sequence result.
	always_comb begin
		keep_payload = 1'b1;
		seq_update   = 1'b0;
		status_n     = ST_OK;
		priority if (!q_rec.size_ok) begin
			status_n     = ST_SIZE;
			keep_payload = 1'b0;
		end else if (q_rec.id != expected_id_q) begin
			status_n     = ST_WRONG_ID;
			keep_payload = 1'b0;
		end else if (!q_rec.crc_ok) begin
			status_n     = ST_WRONG_CRC;
			keep_payload = 1'b0;
		end else if (plaus_en_q && !plaus_ok) begin
			status_n = ST_RANGE;
		end else if (awaiting_first_q) begin
			status_n   = ST_OK;
			seq_update = 1'b1;
		end else if (seq_diff == 16'd0) begin
			status_n   = ST_OK;
			seq_update = 1'b1;
		end else if (!seq_diff[15]) begin
			status_n   = ST_LOST;
			seq_update = 1'b1;
		end else begin
			status_n = ST_REPEATED;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_id_q <= '0;
			plaus_en_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EXPECTED_ID: expected_id_q <= cfg_data;
				CFG_PLAUS_EN:    plaus_en_q    <= cfg_data[0];
				default:         plaus_en_q    <= plaus_en_q;
			endcase
		end
	end

	// Sequence state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_expected_q  <= '0;
			awaiting_first_q <= 1'b1;
			out_valid_q      <= 1'b0;
		end else begin
			if (q_pop) begin
				out_valid_q <= 1'b1;
				if (seq_update) begin
					next_expected_q  <= seq_plus1;
					awaiting_first_q <= 1'b0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			status_q  <= status_n;
			speed_q   <= keep_payload ? q_rec.speed : 32'd0;
			accel_q   <= keep_payload ? q_rec.accel : 32'd0;
			quality_q <= keep_payload ? q_rec.quality : 8'd0;
			seq_q     <= q_rec.seq;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign speed_bits   = speed_q;
	assign accel_bits   = accel_q;
	assign quality_code = quality_q;
	assign seq_number   = seq_q;

endmodule

// File: sv/e2e_message_checker_top.sv
// Top level of the end-to-end message checker: front end, record queue, back end.
// Depends on e2e_pkg, e2e_ingest, e2e_queue and e2e_verdict.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------------
//  in      | input     | in_valid / in_stall | msg_byte, is_last
//  out     | output    | out_valid/out_stall | status, speed_bits, accel_bits, quality_code,
//          |           |                     | seq_number
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One byte is accepted per cycle while in_stall is low; the CRC step and field capture are
// done for each byte as it is accepted. A result enters the record queue when the last byte
// of its message is accepted and is offered from the output register once it leaves the queue.
// The two-entry record queue and the output register let bytes keep flowing while a
// result waits; in_stall rises only when both are full behind a stalled output.
// Reset is asynchronous and clears all control and sequence state at once.
module e2e_message_checker_top #(
	parameter int PAYLOAD_BYTES = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [e2e_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     msg_byte,
	input  logic                           is_last,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     status,
	output logic [31:0]                    speed_bits,
	output logic [31:0]                    accel_bits,
	output logic [7:0]                     quality_code,
	output logic [15:0]                    seq_number
);
	import e2e_pkg::*;

	logic     push;
	logic     full;
	logic     pop;
	logic     head_valid;
	msg_rec_t push_rec;
	msg_rec_t head_rec;

	// Byte intake and classification.
	e2e_ingest #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_ingest (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.msg_byte (msg_byte),
		.is_last  (is_last),
		.q_push   (push),
		.q_rec    (push_rec),
		.q_full   (full)
	);

	// Record queue.
	e2e_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.rec_in  (push_rec),
		.full    (full),
		.pop     (pop),
		.valid   (head_valid),
		.rec_out (head_rec)
	);

	// Status decision and result register.
	e2e_verdict u_verdict (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_valid      (head_valid),
		.q_rec        (head_rec),
		.q_pop        (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.speed_bits   (speed_bits),
		.accel_bits   (accel_bits),
		.quality_code (quality_code),
		.seq_number   (seq_number)
	);

endmodule

// File: sv/e2e_checker.sv
// Port-level checks for the end-to-end message checker, bound to the top level.
// Depends on e2e_pkg and e2e_message_checker_top.
module e2e_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_we,
	input logic [e2e_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0]                    cfg_data,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic [7:0]                     msg_byte,
	input logic                           is_last,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [2:0]                     status,
	input logic [31:0]                    speed_bits,
	input logic [31:0]                    accel_bits,
	input logic [7:0]                     quality_code,
	input logic [15:0]                    seq_number
);
	import e2e_pkg::*;

	// A stalled result stays offered, with its status and sequence number unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(seq_number))
		else $error("stalled result changed");

	// Only defined status codes are produced.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 3'd7)
		else $error("undefined status code");

	// Size, id and CRC errors carry an all-zero payload.
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_SIZE || status == ST_WRONG_ID || status == ST_WRONG_CRC)
		|-> speed_bits == 32'd0 && accel_bits == 32'd0 && quality_code == 8'd0)
		else $error("payload not cleared on rejected message");

endmodule

bind e2e_message_checker_top e2e_checker u_e2e_checker (.*);

// File: bench/e2e_message_checker_top_tb.sv
`timescale 1ns / 1ps
// Testbench for e2e_message_checker_top: messages go in one byte per request, verdicts come out.
// Uses e2e_pkg for status codes and register indexes; every verdict is predicted locally.
module e2e_message_checker_top_tb;
	import e2e_pkg::*;

	localparam int PAYLOAD_BYTES = 12;
	localparam int FRAME_LEN = 12 + PAYLOAD_BYTES;
	localparam int BYTE_TARGET = 1600;
	localparam int PHASES = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 6;
	localparam int DRAIN_CYCLES = 10;

	localparam logic [31:0] POLY_REFL = 32'hEDB8_8320;
	localparam logic [31:0] ONES32 = 32'hFFFF_FFFF;
	localparam logic [30:0] SPD_NEG_LIM = 31'h40A0_0000;
	localparam logic [30:0] SPD_POS_LIM = 31'h42B4_0000;
	localparam logic [30:0] ACC_LIM = 31'h4170_0000;
	localparam logic [7:0] QUAL_LIM = 8'd2;

	// One verdict as it leaves the block.
	typedef struct packed {
		logic [2:0]  st;
		logic [31:0] spd;
		logic [31:0] acc;
		logic [7:0]  qual;
		logic [15:0] seq;
	} verdict_t;

	// Content of one message before it is turned into bytes.
	typedef struct {
		logic [31:0] id;
		logic [15:0] lenf;
		logic [15:0] seq;
		logic [31:0] speed;
		logic [31:0] accel;
		logic [7:0]  quality;
		int          nbytes;
		bit          crc_bad;
		bit          noise;
	} msg_t;

	// One row of the directed table, with an optional register update before it.
	typedef struct {
		bit          set_cfg;
		logic [31:0] cfg_id;
		bit          cfg_plaus;
		msg_t        m;
		bit          typed;
		logic [2:0]  t_st;
	} row_t;

	typedef logic [7:0] byte_list_t[$];

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [7:0] msg_byte;
	logic is_last;
	logic out_valid;
	logic out_stall;
	logic [2:0] status;
	logic [31:0] speed_bits;
	logic [31:0] accel_bits;
	logic [7:0] quality_code;
	logic [15:0] seq_number;

	// Predictor state and its copy of the registers.
	logic [31:0] cfg_id_cur;
	bit          cfg_plaus_cur;
	logic [15:0] next_seq;
	bit          first_pending;
	int          rx_pos;
	logic [31:0] rx_crc;
	logic [31:0] rx_id;
	logic [15:0] rx_seq;
	logic [31:0] rx_crc_field;
	logic [31:0] rx_speed;
	logic [31:0] rx_accel;
	logic [7:0]  rx_quality;

	verdict_t verdict_q[$];
	row_t     rows[$];
	int       err_count = 0;
	int       cycles = 0;
	int       bytes_sent = 0;
	int       stall_hold = 0;
	bit       quiet = 1'b0;

	e2e_message_checker_top #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.msg_byte(msg_byte),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.speed_bits(speed_bits),
		.accel_bits(accel_bits),
		.quality_code(quality_code),
		.seq_number(seq_number)
	);

	// Free-running clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run-away guard.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Length of an idle gap: mostly none or short, now and then long.
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 40);
	endfunction

	// Receiver side: random stall bursts, off entirely during quiet stretches.
	always @(negedge clk) begin
		if (stall_hold > 0) begin
			stall_hold = stall_hold - 1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 35);
			stall_hold = pause_len();
		end
	end

	task automatic note_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		err_count++;
	endtask

	// Compare each delivered verdict with the oldest prediction.
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (verdict_q.size() == 0) begin
				note_mismatch($sformatf("verdict status %0d seq %h with none expected",
					status, seq_number));
			end else begin
				want = verdict_q.pop_front();
				if (status !== want.st)
					note_mismatch($sformatf("status %0d, want %0d (seq %h)",
						status, want.st, want.seq));
				if (speed_bits !== want.spd)
					note_mismatch($sformatf("speed %h, want %h", speed_bits, want.spd));
				if (accel_bits !== want.acc)
					note_mismatch($sformatf("accel %h, want %h", accel_bits, want.acc));
				if (quality_code !== want.qual)
					note_mismatch($sformatf("quality %h, want %h", quality_code, want.qual));
				if (seq_number !== want.seq)
					note_mismatch($sformatf("seq %h, want %h", seq_number, want.seq));
			end
		end
	end

	// One byte of reflected CRC-32.
	function automatic logic [31:0] crc_step(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ POLY_REFL) : (c >> 1);
		end
		return c;
	endfunction

	// Float range test on raw bits; NaN and infinities carry magnitudes above any bound.
	function automatic bit in_band(input logic [31:0] f, input logic [30:0] neg_lim,
			input logic [30:0] pos_lim);
		return f[31] ? (f[30:0] <= neg_lim) : (f[30:0] <= pos_lim);
	endfunction

	function automatic void clear_rx();
		rx_pos = 0;
		rx_crc = ONES32;
		rx_id = '0;
		rx_seq = '0;
		rx_crc_field = '0;
		rx_speed = '0;
		rx_accel = '0;
		rx_quality = '0;
	endfunction

	// Advance the predictor by one accepted byte; returns one when a verdict results.
	function automatic bit track_byte(input logic [7:0] b, input bit last, output verdict_t v);
		int p;
		logic [15:0] gap;
		bit keep;
		p = rx_pos;
		keep = 1'b1;
		v = '0;
		// Field capture by position.
		if (p < 4) begin
			rx_id[8*p +: 8] = b;
		end else if (p == 6 || p == 7) begin
			rx_seq[8*(p-6) +: 8] = b;
		end else if (p >= 8 && p < 12) begin
			rx_crc_field[8*(p-8) +: 8] = b;
		end else if (p >= 12 && p < 16) begin
			rx_speed[8*(p-12) +: 8] = b;
		end else if (p >= 16 && p < 20) begin
			rx_accel[8*(p-16) +: 8] = b;
		end else if (p == 20) begin
			rx_quality = b;
		end
		// The CRC skips its own field.
		if (p < 8 || p >= 12)
			rx_crc = crc_step(rx_crc, b);
		if (p < FRAME_LEN)
			rx_pos = p + 1;
		if (!last)
			return 1'b0;

		// Verdict in order of precedence.
		if (rx_pos < FRAME_LEN) begin
			v.st = ST_SIZE;
			keep = 1'b0;
		end else if (rx_id != cfg_id_cur) begin
			v.st = ST_WRONG_ID;
			keep = 1'b0;
		end else if ((rx_crc ^ ONES32) != rx_crc_field) begin
			v.st = ST_WRONG_CRC;
			keep = 1'b0;
		end else if (cfg_plaus_cur && !(in_band(rx_speed, SPD_NEG_LIM, SPD_POS_LIM) &&
				in_band(rx_accel, ACC_LIM, ACC_LIM) && rx_quality <= QUAL_LIM)) begin
			v.st = ST_RANGE;
		end else if (first_pending) begin
			first_pending = 1'b0;
			next_seq = rx_seq + 16'd1;
			v.st = ST_OK;
		end else begin
			gap = rx_seq - next_seq;
			if (gap == 16'h0) begin
				v.st = ST_OK;
				next_seq = rx_seq + 16'd1;
			end else if (gap < 16'h8000) begin
				v.st = ST_LOST;
				next_seq = rx_seq + 16'd1;
			end else begin
				v.st = ST_REPEATED;
			end
		end
		v.spd = keep ? rx_speed : '0;
		v.acc = keep ? rx_accel : '0;
		v.qual = keep ? rx_quality : '0;
		v.seq = rx_seq;
		clear_rx();
		return 1'b1;
	endfunction

	// Serialize a message, little-endian, with a CRC that may be damaged on purpose.
	function automatic void build_msg(input msg_t m, output byte_list_t q);
		logic [31:0] c;
		logic [7:0] b;
		q = {};
		for (int i = 0; i < m.nbytes; i++) begin
			if (m.noise || i > 20) begin
				b = 8'($urandom);
			end else if (i < 4) begin
				b = m.id[8*i +: 8];
			end else if (i < 6) begin
				b = m.lenf[8*(i-4) +: 8];
			end else if (i < 8) begin
				b = m.seq[8*(i-6) +: 8];
			end else if (i < 12) begin
				b = 8'h00;
			end else if (i < 16) begin
				b = m.speed[8*(i-12) +: 8];
			end else if (i < 20) begin
				b = m.accel[8*(i-16) +: 8];
			end else begin
				b = m.quality;
			end
			q.push_back(b);
		end
		if (!m.noise) begin
			c = ONES32;
			for (int i = 0; i < m.nbytes; i++) begin
				if (i < 8 || i >= 12)
					c = crc_step(c, q[i]);
			end
			c = c ^ ONES32;
			if (m.crc_bad)
				c = c ^ (32'h1 << $urandom_range(0, 31));
			for (int i = 8; i < 12 && i < m.nbytes; i++) begin
				q[i] = c[8*(i-8) +: 8];
			end
		end
	endfunction

	// Offer one byte after a random gap and hold it until accepted. Enters and leaves at a
	// falling edge.
	task automatic send_byte(input logic [7:0] b, input bit last);
		int gap;
		gap = pause_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		msg_byte <= b;
		is_last <= last;
		do begin
			@(posedge clk);
		end while (in_stall !== 1'b0);
		@(negedge clk);
	endtask

	// Predict and send one message; a typed row supplies its own verdict.
	task automatic run_msg(input msg_t m, input bit typed, input logic [2:0] t_st);
		byte_list_t bytes;
		verdict_t v;
		verdict_t tv;
		bit dropped;
		build_msg(m, bytes);
		foreach (bytes[i]) begin
			if (track_byte(bytes[i], i == bytes.size() - 1, v)) begin
				if (typed) begin
					dropped = (t_st == ST_SIZE) || (t_st == ST_WRONG_ID) ||
						(t_st == ST_WRONG_CRC);
					tv.st = t_st;
					tv.spd = dropped ? '0 : m.speed;
					tv.acc = dropped ? '0 : m.accel;
					tv.qual = dropped ? '0 : m.quality;
					tv.seq = (m.nbytes >= 8) ? m.seq :
						(m.nbytes == 7) ? {8'h00, m.seq[7:0]} : 16'h0000;
					verdict_q.push_back(tv);
				end else begin
					verdict_q.push_back(v);
				end
			end
		end
		foreach (bytes[i]) begin
			send_byte(bytes[i], i == bytes.size() - 1);
		end
		bytes_sent += bytes.size();
	endtask

	// Wait until every verdict is out and the pipeline has emptied.
	task automatic settle();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write both registers on back-to-back cycles.
	task automatic write_cfg(input logic [31:0] id, input bit plaus);
		cfg_we <= 1'b1;
		cfg_index <= CFG_EXPECTED_ID;
		cfg_data <= id;
		@(negedge clk);
		cfg_index <= CFG_PLAUS_EN;
		cfg_data <= {31'h0, plaus};
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_id_cur = id;
		cfg_plaus_cur = plaus;
	endtask

	task automatic add_row(input bit set_cfg, input logic [31:0] cfg_id, input bit cfg_plaus,
			input logic [31:0] id, input logic [15:0] lenf, input logic [15:0] seq,
			input logic [31:0] speed, input logic [31:0] accel, input logic [7:0] quality,
			input int nbytes, input bit crc_bad, input bit typed, input logic [2:0] t_st);
		row_t r;
		r.set_cfg = set_cfg;
		r.cfg_id = cfg_id;
		r.cfg_plaus = cfg_plaus;
		r.m.id = id;
		r.m.lenf = lenf;
		r.m.seq = seq;
		r.m.speed = speed;
		r.m.accel = accel;
		r.m.quality = quality;
		r.m.nbytes = nbytes;
		r.m.crc_bad = crc_bad;
		r.m.noise = 1'b0;
		r.typed = typed;
		r.t_st = t_st;
		rows.push_back(r);
	endtask

	// Mostly in range, sometimes a boundary or special value, sometimes any pattern.
	function automatic logic [31:0] pick_float(input logic [30:0] neg_lim,
			input logic [30:0] pos_lim);
		int r;
		logic [30:0] mag;
		r = $urandom_range(0, 99);
		if (r < 75) begin
			if ($urandom_range(0, 1)) begin
				mag = 31'($urandom_range(0, neg_lim));
				return {1'b1, mag};
			end
			mag = 31'($urandom_range(0, pos_lim));
			return {1'b0, mag};
		end else if (r < 92) begin
			case ($urandom_range(0, 9))
				0: return {1'b1, neg_lim};
				1: return {1'b0, pos_lim};
				2: return {1'b1, neg_lim + 31'd1};
				3: return {1'b0, pos_lim + 31'd1};
				4: return 32'h8000_0000;
				5: return 32'h0000_0000;
				6: return 32'h7F80_0000;
				7: return 32'hFF80_0000;
				8: return 32'h7FC0_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom;
	endfunction

	// A random message: mostly well formed and in sequence, the rest broken or noise.
	function automatic void make_random_msg(output msg_t m);
		int r;
		int s;
		r = $urandom_range(0, 99);
		s = $urandom_range(0, 99);
		m.id = cfg_id_cur;
		m.lenf = ($urandom_range(0, 9) < 7) ? 16'(PAYLOAD_BYTES) : 16'($urandom);
		if (s < 70) begin
			m.seq = next_seq;
		end else if (s < 80) begin
			m.seq = next_seq + 16'($urandom_range(1, 6));
		end else if (s < 88) begin
			m.seq = next_seq - 16'($urandom_range(1, 4));
		end else if (s < 94) begin
			m.seq = next_seq + ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
		end else begin
			m.seq = 16'($urandom);
		end
		m.speed = pick_float(SPD_NEG_LIM, SPD_POS_LIM);
		m.accel = pick_float(ACC_LIM, ACC_LIM);
		m.quality = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 2)) : 8'($urandom);
		m.nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(FRAME_LEN + 1, FRAME_LEN + 8)
			: FRAME_LEN;
		m.crc_bad = 1'b0;
		m.noise = 1'b0;
		if (r < 6) begin
			m.noise = 1'b1;
			m.nbytes = $urandom_range(1, FRAME_LEN + 6);
		end else if (r < 12) begin
			m.nbytes = $urandom_range(1, FRAME_LEN - 1);
		end else if (r < 18) begin
			m.id = ($urandom_range(0, 1)) ? (cfg_id_cur ^ (32'h1 << $urandom_range(0, 31)))
				: $urandom;
		end else if (r < 24) begin
			m.crc_bad = 1'b1;
		end
	endfunction

	// Stimulus: directed table, then random phases under changing register settings.
	initial begin
		msg_t m;
		logic [31:0] id;
		bit plaus;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		msg_byte = '0;
		is_last = 1'b0;
		out_stall = 1'b0;
		cfg_id_cur = '0;
		cfg_plaus_cur = 1'b1;
		next_seq = '0;
		first_pending = 1'b1;
		clear_rx();

		//      cfg  cfg_id        pl  id            len     seq       speed         accel
		//      quality nbytes bad typed status
		// Values after reset: expected id 0, range checks on.
		add_row(0, 0, 0, 32'h0000_0000, 16'd12, 16'h0005, 32'h0000_0000, 32'h0000_0000,
			8'd0, FRAME_LEN, 0, 1, ST_OK);
		add_row(0, 0, 0, 32'h0000_0000, 16'd12, 16'h0006, 32'hC0A0_0000, 32'h4170_0000,
			8'd2, FRAME_LEN, 0, 1, ST_OK);
		add_row(0, 0, 0, 32'h0000_0000, 16'd12, 16'h0006, 32'h3F80_0000, 32'h0000_0000,
			8'd1, FRAME_LEN, 0, 1, ST_REPEATED);
		add_row(0, 0, 0, 32'h0000_0000, 16'd12, 16'h0009, 32'h3F80_0000, 32'h0000_0000,
			8'd1, FRAME_LEN, 0, 1, ST_LOST);
		add_row(0, 0, 0, 32'h0000_0000, 16'd12, 16'h0077, 32'h0000_0000, 32'h0000_0000,
			8'd0, 1, 0, 1, ST_SIZE);
		add_row(0, 0, 0, 32'h0000_0000, 16'd12, 16'h1234, 32'h0000_0000, 32'h0000_0000,
			8'd0, FRAME_LEN - 1, 0, 1, ST_SIZE);
		add_row(0, 0, 0, 32'hFFFF_FFFF, 16'd12, 16'h000A, 32'h0000_0000, 32'h0000_0000,
			8'd0, FRAME_LEN, 0, 1, ST_WRONG_ID);
		add_row(0, 0, 0, 32'h0000_0000, 16'd12, 16'h000A, 32'h0000_0000, 32'h0000_0000,
			8'd0, FRAME_LEN, 1, 1, ST_WRONG_CRC);
		add_row(0, 0, 0, 32'h0000_0000, 16'd12, 16'h000A, 32'h42B4_0000, 32'hC170_0000,
			8'd2, FRAME_LEN, 0, 1, ST_OK);
		// NaN speed, then negative zero with an infinite acceleration.
		add_row(0, 0, 0, 32'h0000_0000, 16'd12, 16'h000B, 32'h7FC0_0000, 32'h0000_0000,
			8'd0, FRAME_LEN, 0, 1, ST_RANGE);
		add_row(0, 0, 0, 32'h0000_0000, 16'd12, 16'h000B, 32'h8000_0000, 32'h7F80_0000,
			8'd0, FRAME_LEN, 0, 1, ST_RANGE);
		add_row(0, 0, 0, 32'h0000_0000, 16'd12, 16'h000B, 32'h0000_0000, 32'h0000_0000,
			8'd3, FRAME_LEN, 0, 1, ST_RANGE);
		add_row(0, 0, 0, 32'h0000_0000, 16'd12, 16'h000B, 32'h42B4_0001, 32'h0000_0000,
			8'd0, FRAME_LEN, 0, 1, ST_RANGE);
		add_row(0, 0, 0, 32'h0000_0000, 16'd12, 16'h000B, 32'h0000_0000, 32'hC170_0001,
			8'd0, FRAME_LEN, 0, 1, ST_RANGE);
		// Extra bytes after the payload, a junk length field, and a counter wrap.
		add_row(0, 0, 0, 32'h0000_0000, 16'd12, 16'h000B, 32'h4120_0000, 32'hBF80_0000,
			8'd1, FRAME_LEN + 6, 0, 0, ST_OK);
		add_row(0, 0, 0, 32'h0000_0000, 16'hFFFF, 16'h7FFF, 32'h4120_0000, 32'h0000_0000,
			8'd0, FRAME_LEN, 0, 0, ST_OK);
		add_row(0, 0, 0, 32'h0000_0000, 16'h0000, 16'hFFFF, 32'h4120_0000, 32'h0000_0000,
			8'd0, FRAME_LEN, 0, 0, ST_OK);
		// All-ones id and range checks off.
		add_row(1, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 16'd12, 16'h0000, 32'h7FC0_0000,
			32'hFF80_0000, 8'd255, FRAME_LEN, 0, 0, ST_OK);
		add_row(0, 0, 0, 32'h0000_0000, 16'd12, 16'h0001, 32'h0000_0000, 32'h0000_0000,
			8'd0, FRAME_LEN, 0, 1, ST_WRONG_ID);
		add_row(1, 32'h89AB_CDEF, 1, 32'h89AB_CDEF, 16'd12, 16'h0001, 32'h0000_0000,
			32'h0000_0000, 8'd255, FRAME_LEN, 0, 1, ST_RANGE);
		add_row(0, 0, 0, 32'h89AB_CDEF, 16'd12, 16'h8001, 32'h0000_0000, 32'h0000_0000,
			8'd0, FRAME_LEN, 0, 0, ST_OK);

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].set_cfg) begin
				settle();
				write_cfg(rows[i].cfg_id, rows[i].cfg_plaus);
			end
			run_msg(rows[i].m, rows[i].typed, rows[i].t_st);
		end

		bytes_sent = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				1: begin
					id = 32'h0000_0000;
					plaus = 1'b0;
				end
				2: begin
					id = ONES32;
					plaus = 1'b1;
				end
				3: begin
					id = $urandom;
					plaus = 1'b0;
				end
				default: begin
					id = $urandom;
					plaus = 1'b1;
				end
			endcase
			settle();
			write_cfg(id, plaus);
			while (bytes_sent < (BYTE_TARGET * (ph + 1)) / PHASES) begin
				quiet = ($urandom_range(0, 7) == 0);
				make_random_msg(m);
				run_msg(m, 1'b0, ST_OK);
			end
		end

		// Drain, then give the pipeline time to show anything unexpected.
		in_valid <= 1'b0;
		quiet = 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && verdict_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
